@@ hdl/sfa_pkg.sv @@
// shared constants, types and saturation helpers for the sph force accumulator
`timescale 1ns / 1ps
package sfa_pkg;
  localparam int FRAC_BITS = 16;
  localparam int MASS_W = 31;
  localparam int DEN_W = 31;
  localparam int WORD_W = 32;
  localparam int SUM_W = 48;
  localparam int DIVD_W = 64;
  localparam int QUO_W = 48;
  localparam int REM_W = 32;
  localparam int PROD_W = 66;

  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DEN_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

  function automatic sum_t sat48(input logic signed [SUM_W+2:0] v);
    logic signed [SUM_W+2:0] hi;
    logic signed [SUM_W+2:0] lo;
    hi = (SUM_W+3)'({1'b0, {(SUM_W-1){1'b1}}});
    lo = -hi - (SUM_W+3)'(1);
    if (v > hi) return hi[SUM_W-1:0];
    if (v < lo) return lo[SUM_W-1:0];
    return v[SUM_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] sat32(input logic signed [SUM_W+1:0] v);
    logic signed [SUM_W+1:0] hi;
    logic signed [SUM_W+1:0] lo;
    hi = (SUM_W+2)'({1'b0, {(WORD_W-1){1'b1}}});
    lo = -hi - (SUM_W+2)'(1);
    if (v > hi) return hi[WORD_W-1:0];
    if (v < lo) return lo[WORD_W-1:0];
    return v[WORD_W-1:0];
  endfunction
endpackage

@@ hdl/sfa_if.sv @@
// item and result channel interfaces
`timescale 1ns / 1ps
interface sfa_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic               last_item;
  logic [30:0]        particle_mass;
  logic [30:0]        particle_density;
  logic signed [31:0] kernel_value;
  logic signed [31:0] grad_x;
  logic signed [31:0] grad_y;
  logic signed [31:0] grad_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  modport source (output valid, func, last_item, particle_mass, particle_density,
                  kernel_value, grad_x, grad_y, grad_z, vel_x, vel_y, vel_z,
                  input ready);
  modport sink (input valid, func, last_item, particle_mass, particle_density,
                kernel_value, grad_x, grad_y, grad_z, vel_x, vel_y, vel_z,
                output ready);
endinterface

interface sfa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] acc_x;
  logic signed [31:0] acc_y;
  logic signed [31:0] acc_z;
  modport source (output valid, acc_x, acc_y, acc_z, input ready);
  modport sink (input valid, acc_x, acc_y, acc_z, output ready);
endinterface

@@ hdl/sfa_div.sv @@
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module sfa_div
  import sfa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [REM_W-1:0] rem;
  logic [QUO_W-1:0] quo;
  logic [DEN_W-1:0] den;
  logic [6:0]       cnt;
  logic             done;
  logic [REM_W-1:0] trial;
  logic             fits;

  always_comb begin
    trial = {rem[REM_W-2:0], quo[QUO_W-1]};
    fits = trial >= REM_W'(den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem <= REM_W'(req.dividend[DIVD_W-1:QUO_W]);
        quo <= req.dividend[QUO_W-1:0];
        den <= req.divisor;
        cnt <= 7'(QUO_W);
      end else if (cnt != '0) begin
        rem <= fits ? trial - REM_W'(den) : trial;
        quo <= {quo[QUO_W-2:0], fits};
        cnt <= cnt - 7'd1;
        done <= (cnt == 7'd1);
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = quo;
endmodule

@@ hdl/sph_force_accumulator.sv @@
// sph pressure and viscosity force accumulator, top level and sequencer
//
//  channel  dir  handshake      payload
//  items    in   valid/ready    func, last_item, mass, density, kernel, grad, vel
//  results  out  valid/ready    acc_x, acc_y, acc_z
//
// a load item takes 2 divisions: mass by density, then that ratio by density
// a neighbor takes two divisions and seven multiply steps
// a last neighbor adds three divisions by target density
// all divisions go through the one shared divider; items wait while it runs
// reset clears the target to density one and all sums to zero
// the result register holds under stall; the block stalls only to refill it
`timescale 1ns / 1ps
module sph_force_accumulator
  import sfa_pkg::*;
(
  input logic    clk,
  input logic    rst,
  sfa_in_if.sink items,
  sfa_out_if.source results
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_DIV2 = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;
  localparam logic [2:0] S_FDIV = 3'd5;
  localparam logic [2:0] S_FOUT = 3'd6;

  logic [2:0] state;
  logic [2:0] idx;
  logic [1:0] axis;

  logic                     func;
  logic                     last;
  logic [MASS_W-1:0]        mass;
  logic [DEN_W-1:0]         dens;
  logic signed [WORD_W-1:0] kern;
  logic signed [WORD_W-1:0] grad [3];
  logic signed [WORD_W-1:0] vel [3];

  logic [WORD_W-1:0]        tratio;
  logic [WORD_W-1:0]        nratio;
  logic [DEN_W-1:0]         tdens;
  logic signed [WORD_W-1:0] tvel [3];
  sum_t                     psum [3];
  sum_t                     vsum [3];
  logic [MASS_W-1:0]        coeff;
  logic signed [PROD_W-1:0] prod;
  logic [WORD_W-1:0]        acc [3];
  logic [WORD_W-1:0]        res [3];
  logic                     out_valid;

  div_req_t req;
  div_rsp_t rsp;

  logic [DEN_W-1:0]         din_clamped;
  logic signed [32:0]       op_a;
  logic signed [32:0]       op_b;
  logic [1:0]               fin_axis;
  sum_t                     fin_v;
  logic [SUM_W-1:0]         fin_mag;
  logic signed [PROD_W-FRAC_BITS-1:0] term;
  logic signed [SUM_W+1:0]  fin_sum;
  logic [1:0]               k;

  sfa_div u_div (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  assign items.ready = (state == S_IDLE);
  assign results.valid = out_valid;
  assign results.acc_x = res[0];
  assign results.acc_y = res[1];
  assign results.acc_z = res[2];

  always_comb begin
    din_clamped = items.particle_density;
    if (items.particle_density < DEN_W'(1 << FRAC_BITS)) din_clamped = DEN_W'(1 << FRAC_BITS);
    k = (idx >= 3'd4) ? 2'(idx - 3'd4) : 2'(idx - 3'd1);
    if (idx == 3'd0) begin
      op_a = 33'($unsigned(mass));
      op_b = 33'(tratio) + 33'(nratio);
    end else if (idx <= 3'd3) begin
      op_a = 33'($unsigned(coeff));
      op_b = 33'(grad[k]);
    end else begin
      op_a = 33'(vel[k]) - 33'(tvel[k]);
      op_b = 33'(kern);
    end
    term = prod[PROD_W-1:FRAC_BITS];
    fin_axis = (state == S_ACC) ? 2'd0 : axis + 2'd1;
    fin_v = vsum[fin_axis];
    fin_mag = fin_v[SUM_W-1] ? SUM_W'(-fin_v) : SUM_W'(fin_v);
    if (vsum[axis][SUM_W-1]) fin_sum = (SUM_W+2)'(psum[axis]) - (SUM_W+2)'(rsp.quotient);
    else fin_sum = (SUM_W+2)'(psum[axis]) + (SUM_W+2)'(rsp.quotient);
    req.start = 1'b0;
    req.divisor = dens;
    req.dividend = DIVD_W'(rsp.quotient) << FRAC_BITS;
    case (state)
      S_IDLE: begin
        req.start = items.valid;
        req.divisor = din_clamped;
        req.dividend = DIVD_W'(items.particle_mass) << FRAC_BITS;
      end
      S_DIV1: req.start = rsp.done;
      S_ACC: begin
        req.start = (idx == 3'd6) && last;
        req.divisor = tdens;
        req.dividend = DIVD_W'(fin_mag) << FRAC_BITS;
      end
      S_FDIV: begin
        req.start = rsp.done && (axis != 2'd2);
        req.divisor = tdens;
        req.dividend = DIVD_W'(fin_mag) << FRAC_BITS;
      end
      default: req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      tratio <= '0;
      tdens <= DEN_W'(1 << FRAC_BITS);
      for (int i = 0; i < 3; i++) begin
        tvel[i] <= '0;
        psum[i] <= '0;
        vsum[i] <= '0;
      end
    end else begin
      if (results.valid && results.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (items.valid) begin
            func <= items.func;
            last <= items.last_item;
            mass <= items.particle_mass;
            dens <= din_clamped;
            kern <= items.kernel_value;
            grad[0] <= items.grad_x;
            grad[1] <= items.grad_y;
            grad[2] <= items.grad_z;
            vel[0] <= items.vel_x;
            vel[1] <= items.vel_y;
            vel[2] <= items.vel_z;
            state <= S_DIV1;
          end
        end
        S_DIV1: if (rsp.done) state <= S_DIV2;
        S_DIV2: begin
          if (rsp.done) begin
            if (!func) begin
              tratio <= rsp.quotient[WORD_W-1:0];
              tdens <= dens;
              for (int i = 0; i < 3; i++) begin
                tvel[i] <= vel[i];
                psum[i] <= '0;
                vsum[i] <= '0;
              end
              state <= S_IDLE;
            end else begin
              nratio <= rsp.quotient[WORD_W-1:0];
              idx <= 3'd0;
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          prod <= PROD_W'(op_a) * PROD_W'(op_b);
          state <= S_ACC;
        end
        S_ACC: begin
          if (idx == 3'd0) begin
            coeff <= (prod[PROD_W-1:MASS_W+FRAC_BITS] != '0) ? '1
                   : prod[MASS_W+FRAC_BITS-1:FRAC_BITS];
          end else if (idx <= 3'd3) begin
            psum[k] <= sat48((SUM_W+3)'(psum[k]) - (SUM_W+3)'(term));
          end else begin
            vsum[k] <= sat48((SUM_W+3)'(vsum[k]) + (SUM_W+3)'(term));
          end
          if (idx == 3'd6) begin
            axis <= 2'd0;
            state <= last ? S_FDIV : S_IDLE;
          end else begin
            idx <= idx + 3'd1;
            state <= S_MUL;
          end
        end
        S_FDIV: begin
          if (rsp.done) begin
            acc[axis] <= sat32(fin_sum);
            if (axis == 2'd2) state <= S_FOUT;
            else axis <= axis + 2'd1;
          end
        end
        S_FOUT: begin
          if (!out_valid || results.ready) begin
            out_valid <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              res[i] <= acc[i];
              psum[i] <= '0;
              vsum[i] <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
